// File: rtl/core/nlc_pkg.sv
// ---------------------------------------------------------------------------
// nlc_pkg
// Shared types, codes and character helpers for the numeric literal
// classifier.
// ---------------------------------------------------------------------------
package nlc_pkg;

  typedef enum logic [4:0] {
    PH_START      = 5'd0,
    PH_ZERO       = 5'd1,
    PH_PREFIX     = 5'd2,
    PH_DIGITS     = 5'd3,
    PH_BARE_DOT   = 5'd4,
    PH_EXP_START  = 5'd5,
    PH_EXP_SIGN   = 5'd6,
    PH_EXP_DIGITS = 5'd7,
    PH_FS_D       = 5'd8,
    PH_FS_END     = 5'd9,
    PH_IS_U       = 5'd10,
    PH_IS_UL      = 5'd11,
    PH_IS_UW      = 5'd12,
    PH_IS_L       = 5'd13,
    PH_IS_LL      = 5'd14,
    PH_IS_W       = 5'd15,
    PH_IS_WB      = 5'd16,
    PH_IS_END     = 5'd17
  } phase_t;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_HEX = 2'd1,
    RX_BIN = 2'd2,
    RX_OCT = 2'd3
  } radix_t;

  typedef enum logic [1:0] {
    CLS_INTEGER  = 2'd0,
    CLS_FLOATING = 2'd1,
    CLS_INVALID  = 2'd2
  } class_t;

  localparam logic [7:0] CH_SEP = 8'h27;  // digit separator (single quote)
  localparam logic [7:0] CH_DOT = 8'h2e;

  typedef struct packed {
    phase_t      phase;
    radix_t      radix;
    logic        have_digits;
    logic        prev_sep;
    logic        saw_dot;
    logic        is_float;
    logic        failed;
    logic [7:0]  prev_sfx;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    phase: PH_START, radix: RX_DEC, have_digits: 1'b0, prev_sep: 1'b0,
    saw_dot: 1'b0, is_float: 1'b0, failed: 1'b0, prev_sfx: 8'h00
  };

  function automatic logic in_radix(radix_t rx, logic [7:0] c);
    logic dec;
    dec = (c >= "0") && (c <= "9");
    case (rx)
      RX_HEX: in_radix = dec || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
      RX_BIN: in_radix = (c == "0") || (c == "1");
      RX_OCT: in_radix = (c >= "0") && (c <= "7");
      default: in_radix = dec;
    endcase
  endfunction

endpackage

// File: rtl/core/numeric_literal_classifier_core.sv
// ---------------------------------------------------------------------------
// numeric_literal_classifier_core
// Classifies a C numeric constant streamed one character per request.
// ---------------------------------------------------------------------------
// Send the characters of one preprocessing number in order, one per input
// request, with is_last set on the final one. The block takes one character
// every clock cycle; a character is held in an input register, run through
// the one-step scanner and, if it ends the token, its class is loaded into
// the result register, from which the consumer takes it. Only the last
// character of a token produces a result: 0 integer, 1 floating, 2 invalid.
// The input side stalls only when a finished result still waits in the
// result register and the character in the input register is another token
// end; characters in the middle of a token always move on, so streaming
// stays at one per cycle whenever the consumer keeps out_ready high.
// ---------------------------------------------------------------------------
module numeric_literal_classifier_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           char_code,
  input  logic                 is_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           constant_class
);
  import nlc_pkg::*;

  // input register
  logic        in_q_valid;
  logic [7:0]  in_q_char;
  logic        in_q_last;

  logic        step;
  class_t      step_cls;

  // Advance the held character unless it ends a token and the result slot
  // is still occupied.
  assign step     = in_q_valid && (!in_q_last || !out_valid || out_ready);
  assign in_ready = !in_q_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q_char <= char_code;
      in_q_last <= is_last;
    end
  end

  nlc_scanner u_scan (
    .clk       (clk),
    .rst       (rst),
    .step_en   (step),
    .char_code (in_q_char),
    .is_last   (in_q_last),
    .end_cls   (step_cls)
  );

  // Result register: load on a token end, drop once the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && in_q_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_q_last) begin
      constant_class <= step_cls;
    end
  end

endmodule

// File: rtl/core/nlc_scanner.sv
// ---------------------------------------------------------------------------
// nlc_scanner
// Token scan state and its one-character step; gives the class that the
// token would have if the current character ended it.
// ---------------------------------------------------------------------------
module nlc_scanner (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step_en,
  input  logic [7:0]           char_code,
  input  logic                 is_last,
  output nlc_pkg::class_t      end_cls
);
  import nlc_pkg::*;

  scan_state_t st;
  scan_state_t st_next;

  function automatic scan_state_t float_suffix(scan_state_t s, logic [7:0] c);
    scan_state_t r;
    r = s;
    if (c == "d" || c == "D") begin
      r.prev_sfx = c;
      r.phase    = PH_FS_D;
    end else if (c == "f" || c == "F" || c == "l" || c == "L") begin
      r.phase = PH_FS_END;
    end else begin
      r.failed = 1'b1;
    end
    return r;
  endfunction

  function automatic scan_state_t digits_char(scan_state_t s, logic [7:0] c);
    scan_state_t r;
    logic        exp_ok;
    r = s;
    exp_ok = (c == "e" || c == "E") ? (s.radix == RX_DEC) : (s.radix == RX_HEX);
    if (in_radix(s.radix, c)) begin
      r.prev_sep    = 1'b0;
      r.have_digits = 1'b1;
    end else if (c == CH_SEP) begin
      if (!s.have_digits || s.prev_sep) r.failed = 1'b1;
      r.prev_sep = 1'b1;
    end else if (s.prev_sep) begin
      r.failed = 1'b1;
    end else if (c == CH_DOT) begin
      if (s.saw_dot || s.radix == RX_BIN || s.radix == RX_OCT) begin
        r.failed = 1'b1;
      end else begin
        if (!s.have_digits) r.phase = PH_BARE_DOT;
        r.saw_dot     = 1'b1;
        r.is_float    = 1'b1;
        r.have_digits = 1'b0;
      end
    end else if (c == "e" || c == "E" || c == "p" || c == "P") begin
      if (!exp_ok || (!s.have_digits && !s.saw_dot)) begin
        r.failed = 1'b1;
      end else begin
        r.is_float = 1'b1;
        r.phase    = PH_EXP_START;
      end
    end else if (s.saw_dot) begin
      r = float_suffix(s, c);
    end else if (!s.have_digits) begin
      r.failed = 1'b1;
    end else if (c == "u" || c == "U") begin
      r.phase = PH_IS_U;
    end else if (c == "l" || c == "L" || c == "w" || c == "W") begin
      r.prev_sfx = c;
      r.phase    = (c == "l" || c == "L") ? PH_IS_L : PH_IS_W;
    end else begin
      r.failed = 1'b1;
    end
    return r;
  endfunction

  function automatic class_t end_class(scan_state_t s);
    class_t k;
    k = CLS_INVALID;
    if (!s.failed) begin
      case (s.phase)
        PH_ZERO, PH_IS_U, PH_IS_UL, PH_IS_L, PH_IS_LL, PH_IS_WB, PH_IS_END:
          k = CLS_INTEGER;
        PH_EXP_DIGITS, PH_FS_END:
          k = CLS_FLOATING;
        PH_DIGITS: begin
          if (s.prev_sep || (!s.have_digits && !s.saw_dot)) k = CLS_INVALID;
          else k = s.is_float ? CLS_FLOATING : CLS_INTEGER;
        end
        default: k = CLS_INVALID;
      endcase
    end
    return k;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= SCAN_RESET;
    end else if (step_en) begin
      st <= is_last ? SCAN_RESET : st_next;
    end
  end

  always_comb begin
    logic is_u;
    logic b_ok;
    is_u    = (char_code == "u") || (char_code == "U");
    b_ok    = (st.prev_sfx == "w" && char_code == "b") ||
              (st.prev_sfx == "W" && char_code == "B");
    st_next = st;
    if (!st.failed) begin
      case (st.phase)
        PH_START: begin
          if (char_code == "0") begin
            st_next.phase = PH_ZERO;
          end else begin
            st_next.radix = RX_DEC;
            st_next.phase = PH_DIGITS;
            st_next       = digits_char(st_next, char_code);
          end
        end
        PH_ZERO: begin
          if (char_code == "x" || char_code == "X") begin
            st_next.radix = RX_HEX;
            st_next.phase = PH_PREFIX;
          end else if (char_code == "b" || char_code == "B") begin
            st_next.radix = RX_BIN;
            st_next.phase = PH_PREFIX;
          end else begin
            st_next.radix       = RX_OCT;
            st_next.have_digits = 1'b1;
            st_next.phase       = PH_DIGITS;
            st_next             = digits_char(st_next, char_code);
          end
        end
        PH_PREFIX: begin
          st_next.phase = PH_DIGITS;
          st_next       = digits_char(st_next, char_code);
        end
        PH_DIGITS: st_next = digits_char(st, char_code);
        PH_BARE_DOT: begin
          if (in_radix(st.radix, char_code)) begin
            st_next.have_digits = 1'b1;
            st_next.phase       = PH_DIGITS;
          end else begin
            st_next.failed = 1'b1;
          end
        end
        PH_EXP_START: begin
          if (char_code == "+" || char_code == "-") st_next.phase = PH_EXP_SIGN;
          else if (in_radix(st.radix, char_code)) st_next.phase = PH_EXP_DIGITS;
          else st_next.failed = 1'b1;
        end
        PH_EXP_SIGN: begin
          if (in_radix(st.radix, char_code)) st_next.phase = PH_EXP_DIGITS;
          else st_next.failed = 1'b1;
        end
        PH_EXP_DIGITS: begin
          if (!in_radix(st.radix, char_code)) st_next = float_suffix(st, char_code);
        end
        PH_FS_D: begin
          if ((st.prev_sfx == "d" &&
               (char_code == "f" || char_code == "d" || char_code == "l")) ||
              (st.prev_sfx == "D" &&
               (char_code == "F" || char_code == "D" || char_code == "L")))
            st_next.phase = PH_FS_END;
          else
            st_next.failed = 1'b1;
        end
        PH_IS_U: begin
          if (char_code == "l" || char_code == "L" || char_code == "w" || char_code == "W") begin
            st_next.prev_sfx = char_code;
            st_next.phase    = (char_code == "l" || char_code == "L") ? PH_IS_UL : PH_IS_UW;
          end else begin
            st_next.failed = 1'b1;
          end
        end
        PH_IS_UL: begin
          if (char_code == st.prev_sfx) st_next.phase = PH_IS_END;
          else st_next.failed = 1'b1;
        end
        PH_IS_UW: begin
          if (b_ok) st_next.phase = PH_IS_END;
          else st_next.failed = 1'b1;
        end
        PH_IS_L: begin
          if (char_code == st.prev_sfx) st_next.phase = PH_IS_LL;
          else if (is_u) st_next.phase = PH_IS_END;
          else st_next.failed = 1'b1;
        end
        PH_IS_W: begin
          if (b_ok) st_next.phase = PH_IS_WB;
          else st_next.failed = 1'b1;
        end
        PH_IS_LL, PH_IS_WB: begin
          if (is_u) st_next.phase = PH_IS_END;
          else st_next.failed = 1'b1;
        end
        default: st_next.failed = 1'b1;
      endcase
    end
    end_cls = end_class(st_next);
  end

endmodule

// File: rtl/core/nlc_checker.sv
// ---------------------------------------------------------------------------
// nlc_checker
// Port-level checks on the numeric literal classifier.
// ---------------------------------------------------------------------------
module nlc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        is_last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  constant_class
);
  import nlc_pkg::*;

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(constant_class))
    else $error("stalled result changed");

  // only defined class codes leave the block
  a_class_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (constant_class == CLS_INTEGER || constant_class == CLS_FLOATING ||
                   constant_class == CLS_INVALID))
    else $error("undefined class code");

  // with no result waiting, the input side never stalls
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind numeric_literal_classifier_core nlc_checker u_nlc_checker (.*);

// File: dv/tb_numeric_literal_classifier_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_numeric_literal_classifier_core
// Streams C numeric constants through the classifier one character per
// request and checks every reported class against a scanner model kept in
// the bench. Directed tokens cover the grammar corners. Random tokens are
// mostly well formed, with a share of damaged tokens and byte noise. Both
// handshake sides idle at random, and one long output stall backs the block
// up to its input.
// ---------------------------------------------------------------------------
module tb_numeric_literal_classifier_core;
  import nlc_pkg::*;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] char_code;
  logic       is_last;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] constant_class;

  numeric_literal_classifier_core DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .char_code      (char_code),
    .is_last        (is_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .constant_class (constant_class)
  );

  // Scanner model state: one token in flight at a time.
  phase_t     lx_phase;
  radix_t     lx_radix;
  bit         lx_digits;
  bit         lx_sep;
  bit         lx_dot;
  bit         lx_float;
  bit         lx_failed;
  logic [7:0] lx_sfx;

  // Classes still owed by the block, oldest first.
  class_t     class_q[$];
  // Characters of the token being built or sent.
  logic [7:0] tok_buf[$];

  int         fail_count = 0;
  int         result_count = 0;
  bit         src_burst = 1'b0;
  bit         sink_burst = 1'b0;
  bit         sink_hold = 1'b0;
  int         hold_cycles = 0;
  int         stall_left = 0;
  class_t     want;
  event       hold_go;

  // -------------------------------------------------------------------------
  // Clock, reset and the run limit
  // -------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run of this stimulus.
  initial begin
    #10_000_000;
    $display("** numeric_literal_classifier_core: FAILED **");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Scanner model
  // -------------------------------------------------------------------------
  function automatic void lex_reset_state();
    lx_phase  = PH_START;
    lx_radix  = RX_DEC;
    lx_digits = 1'b0;
    lx_sep    = 1'b0;
    lx_dot    = 1'b0;
    lx_float  = 1'b0;
    lx_failed = 1'b0;
    lx_sfx    = 8'h00;
  endfunction

  function automatic bit in_current_radix(logic [7:0] c);
    bit ok;
    case (lx_radix)
      RX_HEX: ok = (c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
                   (c >= "A" && c <= "F");
      RX_BIN: ok = (c == "0") || (c == "1");
      RX_OCT: ok = (c >= "0") && (c <= "7");
      default: ok = (c >= "0") && (c <= "9");
    endcase
    return ok;
  endfunction

  function automatic bit closes_wb(logic [7:0] c);
    return (lx_sfx == "w" && c == "b") || (lx_sfx == "W" && c == "B");
  endfunction

  function automatic void take_float_suffix(logic [7:0] c);
    if (c == "d" || c == "D") begin
      lx_sfx   = c;
      lx_phase = PH_FS_D;
    end else if (c == "f" || c == "F" || c == "l" || c == "L") begin
      lx_phase = PH_FS_END;
    end else begin
      lx_failed = 1'b1;
    end
  endfunction

  // Mantissa body: digits, separators, dot, exponent start, suffix entry.
  function automatic void scan_number_char(logic [7:0] c);
    bit exp_ok;
    exp_ok = (c == "e" || c == "E") ? (lx_radix == RX_DEC) : (lx_radix == RX_HEX);
    if (in_current_radix(c)) begin
      lx_sep    = 1'b0;
      lx_digits = 1'b1;
    end else if (c == CH_SEP) begin
      if (!lx_digits || lx_sep)
        lx_failed = 1'b1;
      lx_sep = 1'b1;
    end else if (lx_sep) begin
      lx_failed = 1'b1;
    end else if (c == CH_DOT) begin
      if (lx_dot || lx_radix == RX_BIN || lx_radix == RX_OCT) begin
        lx_failed = 1'b1;
      end else begin
        if (!lx_digits)
          lx_phase = PH_BARE_DOT;
        lx_dot    = 1'b1;
        lx_float  = 1'b1;
        lx_digits = 1'b0;
      end
    end else if (c == "e" || c == "E" || c == "p" || c == "P") begin
      if (!exp_ok || (!lx_digits && !lx_dot)) begin
        lx_failed = 1'b1;
      end else begin
        lx_float = 1'b1;
        lx_phase = PH_EXP_START;
      end
    end else if (lx_dot) begin
      take_float_suffix(c);
    end else if (!lx_digits) begin
      lx_failed = 1'b1;
    end else if (c == "u" || c == "U") begin
      lx_phase = PH_IS_U;
    end else if (c == "l" || c == "L") begin
      lx_sfx   = c;
      lx_phase = PH_IS_L;
    end else if (c == "w" || c == "W") begin
      lx_sfx   = c;
      lx_phase = PH_IS_W;
    end else begin
      lx_failed = 1'b1;
    end
  endfunction

  function automatic void advance_lexer(logic [7:0] c);
    bit is_u;
    is_u = (c == "u") || (c == "U");
    case (lx_phase)
      PH_START: begin
        if (c == "0") begin
          lx_phase = PH_ZERO;
        end else begin
          lx_radix = RX_DEC;
          lx_phase = PH_DIGITS;
          scan_number_char(c);
        end
      end
      PH_ZERO: begin
        if (c == "x" || c == "X") begin
          lx_radix = RX_HEX;
          lx_phase = PH_PREFIX;
        end else if (c == "b" || c == "B") begin
          lx_radix = RX_BIN;
          lx_phase = PH_PREFIX;
        end else begin
          // The leading zero itself counts as an octal digit.
          lx_radix  = RX_OCT;
          lx_digits = 1'b1;
          lx_phase  = PH_DIGITS;
          scan_number_char(c);
        end
      end
      PH_PREFIX: begin
        lx_phase = PH_DIGITS;
        scan_number_char(c);
      end
      PH_DIGITS: scan_number_char(c);
      PH_BARE_DOT: begin
        if (in_current_radix(c)) begin
          lx_digits = 1'b1;
          lx_phase  = PH_DIGITS;
        end else begin
          lx_failed = 1'b1;
        end
      end
      PH_EXP_START: begin
        if (c == "+" || c == "-")
          lx_phase = PH_EXP_SIGN;
        else if (in_current_radix(c))
          lx_phase = PH_EXP_DIGITS;
        else
          lx_failed = 1'b1;
      end
      PH_EXP_SIGN: begin
        if (in_current_radix(c))
          lx_phase = PH_EXP_DIGITS;
        else
          lx_failed = 1'b1;
      end
      PH_EXP_DIGITS: begin
        if (!in_current_radix(c))
          take_float_suffix(c);
      end
      PH_FS_D: begin
        if ((lx_sfx == "d" && (c == "f" || c == "d" || c == "l")) ||
            (lx_sfx == "D" && (c == "F" || c == "D" || c == "L")))
          lx_phase = PH_FS_END;
        else
          lx_failed = 1'b1;
      end
      PH_IS_U: begin
        if (c == "l" || c == "L") begin
          lx_sfx   = c;
          lx_phase = PH_IS_UL;
        end else if (c == "w" || c == "W") begin
          lx_sfx   = c;
          lx_phase = PH_IS_UW;
        end else begin
          lx_failed = 1'b1;
        end
      end
      PH_IS_UL: begin
        if (c == lx_sfx)
          lx_phase = PH_IS_END;
        else
          lx_failed = 1'b1;
      end
      PH_IS_UW: begin
        if (closes_wb(c))
          lx_phase = PH_IS_END;
        else
          lx_failed = 1'b1;
      end
      PH_IS_L: begin
        if (c == lx_sfx)
          lx_phase = PH_IS_LL;
        else if (is_u)
          lx_phase = PH_IS_END;
        else
          lx_failed = 1'b1;
      end
      PH_IS_W: begin
        if (closes_wb(c))
          lx_phase = PH_IS_WB;
        else
          lx_failed = 1'b1;
      end
      PH_IS_LL, PH_IS_WB: begin
        if (is_u)
          lx_phase = PH_IS_END;
        else
          lx_failed = 1'b1;
      end
      default: lx_failed = 1'b1;
    endcase
  endfunction

  function automatic class_t token_class();
    class_t k;
    k = CLS_INVALID;
    if (!lx_failed) begin
      case (lx_phase)
        PH_ZERO, PH_IS_U, PH_IS_UL, PH_IS_L, PH_IS_LL, PH_IS_WB, PH_IS_END:
          k = CLS_INTEGER;
        PH_EXP_DIGITS, PH_FS_END:
          k = CLS_FLOATING;
        PH_DIGITS: begin
          if (lx_sep || (!lx_digits && !lx_dot))
            k = CLS_INVALID;
          else if (lx_float)
            k = CLS_FLOATING;
          else
            k = CLS_INTEGER;
        end
        default: k = CLS_INVALID;
      endcase
    end
    return k;
  endfunction

  // Fold one accepted character into the model; owe a class on token end.
  function automatic void predict_char(logic [7:0] c, bit last);
    if (!lx_failed)
      advance_lexer(c);
    if (last) begin
      class_q.push_back(token_class());
      lex_reset_state();
    end
  endfunction

  // -------------------------------------------------------------------------
  // Token building
  // -------------------------------------------------------------------------
  function automatic void append_text(string s);
    for (int i = 0; i < s.len(); i++)
      tok_buf.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_char(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic void append_digits(radix_t rx, int n, bit allow_sep);
    string set;
    case (rx)
      RX_HEX: set = "0123456789abcdefABCDEF";
      RX_BIN: set = "01";
      RX_OCT: set = "01234567";
      default: set = "0123456789";
    endcase
    for (int i = 0; i < n; i++) begin
      tok_buf.push_back(pick_char(set));
      if (allow_sep && i < n - 1 && $urandom_range(0, 5) == 0)
        tok_buf.push_back(CH_SEP);
    end
  endfunction

  function automatic void append_int_suffix();
    string      tmpl;
    logic [7:0] ch;
    bit         up_u;
    bit         up_l;
    bit         up_w;
    up_u = 1'($urandom_range(0, 1));
    up_l = 1'($urandom_range(0, 1));
    up_w = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 10))
      0: tmpl = "u";
      1: tmpl = "ul";
      2: tmpl = "ull";
      3: tmpl = "uwb";
      4: tmpl = "l";
      5: tmpl = "lu";
      6: tmpl = "ll";
      7: tmpl = "llu";
      8: tmpl = "wb";
      9: tmpl = "wbu";
      default: tmpl = "";
    endcase
    // Upper-case each letter family as one unit, so ll and wb stay legal.
    for (int i = 0; i < tmpl.len(); i++) begin
      ch = tmpl[i];
      if ((ch == "u" && up_u) || (ch == "l" && up_l) ||
          ((ch == "w" || ch == "b") && up_w))
        ch = ch - 8'd32;
      tok_buf.push_back(ch);
    end
  endfunction

  function automatic void append_float_suffix();
    case ($urandom_range(0, 12))
      0: append_text("f");
      1: append_text("F");
      2: append_text("l");
      3: append_text("L");
      4: append_text("df");
      5: append_text("dd");
      6: append_text("dl");
      7: append_text("DF");
      8: append_text("DD");
      9: append_text("DL");
      default: ;
    endcase
  endfunction

  // Mostly well-formed constants with random content, some damaged, some noise.
  function automatic void build_random_token();
    radix_t rx;
    int     form;
    int     pos;
    bit     lead_digits;
    tok_buf.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4))
        tok_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end
    rx = radix_t'($urandom_range(0, 3));
    case (rx)
      RX_HEX: append_text($urandom_range(0, 1) ? "0x" : "0X");
      RX_BIN: append_text($urandom_range(0, 1) ? "0b" : "0B");
      RX_OCT: append_text("0");
      default: ;
    endcase
    lead_digits = !(rx == RX_DEC && $urandom_range(0, 7) == 0);
    if ((rx == RX_DEC || rx == RX_HEX) && $urandom_range(0, 1)) begin
      form = $urandom_range(0, 2);   // dot only, exponent only, both
      if (!lead_digits)
        form = (form == 1) ? 0 : form;
      if (lead_digits)
        append_digits(rx, $urandom_range(1, 5), 1'b1);
      if (form != 1) begin
        tok_buf.push_back(CH_DOT);
        append_digits(rx, lead_digits ? $urandom_range(0, 3) : $urandom_range(1, 3), 1'b1);
      end
      if (form != 0) begin
        if (rx == RX_HEX)
          tok_buf.push_back($urandom_range(0, 1) ? "p" : "P");
        else
          tok_buf.push_back($urandom_range(0, 1) ? "e" : "E");
        case ($urandom_range(0, 2))
          0: tok_buf.push_back("+");
          1: tok_buf.push_back("-");
          default: ;
        endcase
        append_digits(rx, $urandom_range(1, 3), 1'b0);
      end
      append_float_suffix();
    end else begin
      if (rx != RX_OCT || $urandom_range(0, 3) != 0)
        append_digits(rx, $urandom_range(1, 6), 1'b1);
      append_int_suffix();
    end
    // Damage about a quarter of the tokens.
    if ($urandom_range(0, 3) == 0) begin
      pos = $urandom_range(0, tok_buf.size() - 1);
      case ($urandom_range(0, 3))
        0: tok_buf[pos] = pick_char("0123456789abcdefxXpPeE+-.'uUlLwWbBdDfF");
        1: tok_buf[pos] = 8'($urandom_range(0, 255));
        2: if (tok_buf.size() > 1) void'(tok_buf.pop_back());
        default: tok_buf.push_back(pick_char("0123456789eEpP+-.'uUlLwWbBdDfF"));
      endcase
    end
  endfunction

  // -------------------------------------------------------------------------
  // Request side
  // -------------------------------------------------------------------------
  // Offer one character and hold it until the block takes it. Valid stays
  // high after acceptance; the next call either reuses it or drops it for a gap.
  task automatic send_char(logic [7:0] c, bit last);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    is_last   <= last;
    do @(posedge clk); while (!in_ready);
    predict_char(c, last);
  endtask

  task automatic send_token();
    if (tok_buf.size() == 0)
      tok_buf.push_back("1");
    for (int i = 0; i < tok_buf.size(); i++)
      send_char(tok_buf[i], i == tok_buf.size() - 1);
  endtask

  task automatic send_text(string s);
    tok_buf.delete();
    append_text(s);
    send_token();
  endtask

  // Drop valid and hold the input until every owed class has come back.
  // The loop waits on the clock before its first check, so valid is never
  // lowered and raised in the same step.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (class_q.size() != 0);
  endtask

  // -------------------------------------------------------------------------
  // Result side: random stalls, long hold-off, and the checker
  // -------------------------------------------------------------------------
  initial forever begin
    @(hold_go);
    sink_hold <= 1'b1;
    repeat (hold_cycles) @(posedge clk);
    sink_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        result_count++;
        if (class_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result #%0d: class %0d", result_count, constant_class);
          fail_count++;
        end else begin
          want = class_q.pop_front();
          if (constant_class !== want) begin
            if (fail_count < 10)
              $display("result #%0d: class expected %0d, got %0d",
                       result_count, want, constant_class);
            fail_count++;
          end
        end
        stall_left = sink_burst ? 0 : $urandom_range(0, 19);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0) && !sink_hold;
    end
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  task automatic test_directed_tokens();
    src_burst  = 1'b0;
    sink_burst = 1'b0;
    send_text("0");
    send_text("0x1.8p+3f");
    send_text("0B1'01uwb");
    send_text("1'000ull");
    send_text("017LLu");
    send_text("1.5e-5dd");
    send_text(".5DF");
    send_text("0x1.8");          // hex float without exponent
    send_text("0x1e5");          // e is a hex digit here
    send_text("0x1pAL");         // exponent digits follow the radix
    send_text("5WBu");
    send_text("9Lu");
    send_text("0x");             // empty prefix
    send_text("0b");
    send_text("1'");             // separator at the end
    send_text("0x'1");           // separator right after the prefix
    send_text("1.'5");           // separator right after the dot
    send_text("1e+'5");          // separator inside the exponent
    send_text("0.5");            // octal with a dot
    send_text("0b12");
    send_text("9lL");            // mixed-case ll
    send_text("1.5ff");          // nothing after a float suffix
    send_text("1.e3dl");
    // Bytes outside the grammar, including both ends of the byte range.
    tok_buf.delete();
    tok_buf.push_back("7");
    tok_buf.push_back(8'h00);
    send_token();
    tok_buf.delete();
    tok_buf.push_back(8'hff);
    send_token();
    wait_results_drained();
  endtask

  // Stall the result side for a long stretch while short tokens keep coming,
  // so the block backs up and drops in_ready.
  task automatic test_output_backpressure();
    src_burst   = 1'b1;
    sink_burst  = 1'b1;
    hold_cycles = 150;
    -> hold_go;
    for (int i = 0; i < 12; i++) begin
      case (i % 3)
        0: send_text("7");
        1: send_text("0x");
        default: send_text("2.5");
      endcase
    end
    wait_results_drained();
  endtask

  task automatic test_random_tokens(int char_target);
    int sent_chars;
    int tok_no;
    sent_chars = 0;
    tok_no     = 0;
    while (sent_chars < char_target) begin
      // Switch idling styles now and then to get gap-free stretches too.
      if (tok_no % 16 == 0) begin
        src_burst  = ($urandom_range(0, 3) == 0);
        sink_burst = ($urandom_range(0, 3) == 0);
      end
      if (tok_no % 60 == 59)
        wait_results_drained();
      build_random_token();
      sent_chars += tok_buf.size();
      send_token();
      tok_no++;
    end
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    char_code <= 8'h00;
    is_last   <= 1'b0;
    lex_reset_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_tokens();
    test_output_backpressure();
    test_random_tokens(460);

    wait_results_drained();
    repeat (6) @(posedge clk);
    if (fail_count == 0 && class_q.size() == 0)
      $display("** numeric_literal_classifier_core: PASSED **");
    else
      $display("** numeric_literal_classifier_core: FAILED **");
    $finish;
  end

endmodule
